FILE: hdl/srf_pkg.sv
// ----------------------------------------------------------------------------
// Sheared scaled rectangle fill: shared definitions
// Payload types, command and status bundles, codes and screen constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srf_pkg;

  // Screen geometry of the frame buffer.
  localparam int unsigned SCREEN_W = 128;
  localparam int unsigned SCREEN_H = 128;

  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Shared multiplier: 17-bit signed by 32-bit signed.
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Exact column sum and the row compare width.
  localparam int unsigned COL_W = 36;
  localparam int unsigned ROW_W = 18;

  // Slots of the held shear factors.
  localparam int unsigned SHEAR_ROW    = 0;
  localparam int unsigned SHEAR_COLUMN = 1;
  localparam int unsigned SHEAR_SECOND = 2;
  localparam int unsigned SHEAR_N      = 3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_LEFT   = 2'd0,
    CFG_VIEW_TOP    = 2'd1,
    CFG_VIEW_WIDTH  = 2'd2,
    CFG_VIEW_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_WIDTH,
    MUL_HEIGHT,
    MUL_XSHIFT,
    MUL_XSECOND
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXT_X_MUL,
    S_EXT_X,
    S_EXT_Y,
    S_XS_MUL,
    S_ROW,
    S_X2_MUL,
    S_COL,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        fill_color;
    logic signed [15:0] corner_x;
    logic signed [15:0] corner_y;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] row_shear;
    logic signed [31:0] column_shear;
    logic signed [31:0] second_shear;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [15:0]       pixel_color;
    logic              write_enable;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ext_x;
    logic     ext_y;
    logic     row_load;
    logic     vacc_load;
    logic     col_load;
    logic     emit_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/srf_ctrl.sv
// ----------------------------------------------------------------------------
// Sheared scaled rectangle fill: controller
// Sequences start and step transactions through the shared datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_opcode_i,
  input  srf_pkg::status_t status_i,
  output logic             in_stall_o,
  output srf_pkg::cmd_t    cmd_o
);

  srf_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_stall_o = (state_q != srf_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srf_pkg::S_IDLE: begin
        if (accept) begin
          if (in_opcode_i == srf_pkg::OP_START) begin
            state_d = srf_pkg::S_EXT_X_MUL;
          end else if (status_i.busy) begin
            state_d = srf_pkg::S_XS_MUL;
          end else begin
            state_d = srf_pkg::S_EMIT;
          end
        end
      end
      srf_pkg::S_EXT_X_MUL: state_d = srf_pkg::S_EXT_X;
      srf_pkg::S_EXT_X:     state_d = srf_pkg::S_EXT_Y;
      srf_pkg::S_EXT_Y:     state_d = srf_pkg::S_IDLE;
      srf_pkg::S_XS_MUL:    state_d = srf_pkg::S_ROW;
      srf_pkg::S_ROW:       state_d = srf_pkg::S_X2_MUL;
      srf_pkg::S_X2_MUL:    state_d = srf_pkg::S_COL;
      srf_pkg::S_COL:       state_d = srf_pkg::S_EMIT;
      srf_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          state_d = srf_pkg::S_IDLE;
        end
      end
      default: state_d = srf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = srf_pkg::MUL_WIDTH;
    cmd_o.capture = accept;
    unique case (state_q)
      srf_pkg::S_IDLE: begin
      end
      srf_pkg::S_EXT_X_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = srf_pkg::MUL_WIDTH;
      end
      srf_pkg::S_EXT_X: begin
        cmd_o.ext_x   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = srf_pkg::MUL_HEIGHT;
      end
      srf_pkg::S_EXT_Y: begin
        cmd_o.ext_y = 1'b1;
      end
      srf_pkg::S_XS_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = srf_pkg::MUL_XSHIFT;
      end
      srf_pkg::S_ROW: begin
        cmd_o.row_load = 1'b1;
      end
      srf_pkg::S_X2_MUL: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = srf_pkg::MUL_XSECOND;
        cmd_o.vacc_load = 1'b1;
      end
      srf_pkg::S_COL: begin
        cmd_o.col_load = 1'b1;
      end
      srf_pkg::S_EMIT: begin
        cmd_o.emit_load = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/srf_datapath.sv
// ----------------------------------------------------------------------------
// Sheared scaled rectangle fill: datapath
// Viewport registers, rectangle state, shared multiplier and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srf_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srf_pkg::cmd_t                   cmd_i,
  input  srf_pkg::in_item_t               in_data_i,
  input  logic                            cfg_we_i,
  input  logic [srf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            out_stall_i,
  output srf_pkg::status_t                status_o,
  output logic                            out_valid_o,
  output srf_pkg::out_item_t              out_data_o
);

  localparam int unsigned ColPad = srf_pkg::COL_W - 16;
  localparam int unsigned RowPad = srf_pkg::ROW_W - 16;

  // Viewport configuration.
  logic signed [15:0] view_left_q, view_top_q;
  logic [15:0]        view_width_q, view_height_q;

  // Captured transaction and rectangle state.
  srf_pkg::in_item_t  in_q;
  logic signed [15:0] start_column_q, start_column_d;
  logic signed [15:0] start_row_q, start_row_d;
  logic [15:0]        span_columns_q, span_columns_d;
  logic [15:0]        span_rows_q, span_rows_d;
  logic [15:0]        row_count_q, row_count_d;
  logic [15:0]        column_count_q, column_count_d;
  logic [31:0]        row_shift_acc_q, row_shift_acc_d;
  logic [31:0]        vertical_acc_q, vertical_acc_d;
  logic [15:0]        held_color_q, held_color_d;
  logic [31:0]        held_shears_q [srf_pkg::SHEAR_N];
  logic [31:0]        held_shears_d [srf_pkg::SHEAR_N];
  logic               busy_q, busy_d;

  // Shared multiplier.
  logic signed [srf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [srf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [srf_pkg::PROD_W-1:0]  product_d, product_q;

  // Per-pixel intermediates.
  logic signed [15:0]               xs;
  logic signed [15:0]               row_s;
  logic signed [16:0]               row_delta;
  logic [15:0]                      row_base;
  logic [31:0]                      yp_d, yp_q;
  logic signed [32:0]               x2;
  logic signed [srf_pkg::COL_W-1:0] col_d, col_q;

  // Extent of the product held in the multiplier register.
  logic signed [32:0] ext_val;
  logic [32:0]        ext_abs;
  logic [15:0]        ext_span, ext_shift;

  // Clipping and addressing.
  logic signed [srf_pkg::COL_W-1:0] left_ext, right_ext, scr_w_ext;
  logic signed [srf_pkg::ROW_W-1:0] row_ext, top_ext, bottom_ext, scr_h_ext;
  logic                             col_ok, row_ok, on_screen;
  logic [srf_pkg::ADDR_W-1:0]       pix_addr;
  logic [16:0]                      col_next, row_next;
  logic                             col_end, row_end;

  srf_pkg::out_item_t out_q, out_d;
  logic               out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_left_q   <= '0;
      view_top_q    <= '0;
      view_width_q  <= 16'd128;
      view_height_q <= 16'd128;
    end else if (cfg_we_i) begin
      unique case (srf_pkg::cfg_idx_e'(cfg_index_i))
        srf_pkg::CFG_VIEW_LEFT:   view_left_q   <= cfg_data_i;
        srf_pkg::CFG_VIEW_TOP:    view_top_q    <= cfg_data_i;
        srf_pkg::CFG_VIEW_WIDTH:  view_width_q  <= cfg_data_i;
        srf_pkg::CFG_VIEW_HEIGHT: view_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  assign xs        = row_shift_acc_q[31:16];
  assign row_s     = yp_q[31:16];
  assign row_delta = {row_s[15], row_s} - {start_row_q[15], start_row_q};

  always_comb begin
    unique case (cmd_i.mul_sel)
      srf_pkg::MUL_WIDTH: begin
        mul_a = {1'b0, in_q.rect_width};
        mul_b = in_q.scale_x;
      end
      srf_pkg::MUL_HEIGHT: begin
        mul_a = {1'b0, in_q.rect_height};
        mul_b = in_q.scale_y;
      end
      srf_pkg::MUL_XSHIFT: begin
        mul_a = {xs[15], xs};
        mul_b = held_shears_q[srf_pkg::SHEAR_COLUMN];
      end
      srf_pkg::MUL_XSECOND: begin
        mul_a = row_delta;
        mul_b = held_shears_q[srf_pkg::SHEAR_SECOND];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      product_q <= product_d;
    end
  end

  // Floor of the scaled size; a negative extent mirrors about the corner.
  assign ext_val   = product_q[srf_pkg::PROD_W-1:16];
  assign ext_abs   = ext_val[32] ? 33'(-ext_val) : 33'(ext_val);
  assign ext_span  = (ext_abs > 33'd65535) ? 16'hFFFF : ext_abs[15:0];
  assign ext_shift = ext_val[32] ? ext_span : 16'd0;

  // Sheared row: restart from the row base at the first column.
  assign row_base = start_row_q + row_count_q;
  assign yp_d     = (column_count_q == '0) ? ({row_base, 16'h0000} + product_q[31:0])
                                           : vertical_acc_q;

  assign x2    = product_q[srf_pkg::PROD_W-1:16];
  assign col_d = {{ColPad{start_column_q[15]}}, start_column_q}
               + {{ColPad{1'b0}}, column_count_q}
               + {{ColPad{xs[15]}}, xs}
               + {{(srf_pkg::COL_W - 33){x2[32]}}, x2};

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_load) begin
      yp_q <= yp_d;
    end
    if (cmd_i.col_load) begin
      col_q <= col_d;
    end
  end

  assign left_ext   = {{ColPad{view_left_q[15]}}, view_left_q};
  assign right_ext  = left_ext + {{ColPad{1'b0}}, view_width_q};
  assign scr_w_ext  = srf_pkg::COL_W'(srf_pkg::SCREEN_W);
  assign row_ext    = {{RowPad{row_s[15]}}, row_s};
  assign top_ext    = {{RowPad{view_top_q[15]}}, view_top_q};
  assign bottom_ext = top_ext + {{RowPad{1'b0}}, view_height_q};
  assign scr_h_ext  = srf_pkg::ROW_W'(srf_pkg::SCREEN_H);

  assign col_ok = (col_q >= left_ext) && (col_q < right_ext) &&
                  !col_q[srf_pkg::COL_W-1] && (col_q < scr_w_ext);
  assign row_ok = (row_ext >= top_ext) && (row_ext < bottom_ext) &&
                  !row_s[15] && (row_ext < scr_h_ext);
  assign on_screen = col_ok && row_ok;

  assign pix_addr = srf_pkg::ADDR_W'(32'(row_s[15:0]) * srf_pkg::SCREEN_W
                                     + 32'(col_q[15:0]));

  assign col_next = {1'b0, column_count_q} + 17'd1;
  assign row_next = {1'b0, row_count_q} + 17'd1;
  assign col_end  = (col_next >= {1'b0, span_columns_q});
  assign row_end  = (row_next >= {1'b0, span_rows_q});

  always_comb begin
    out_d.pixel_color = held_color_q;
    if (busy_q) begin
      out_d.pixel_address = on_screen ? pix_addr : '0;
      out_d.write_enable  = on_screen;
      out_d.last          = col_end && row_end;
    end else begin
      out_d.pixel_address = '0;
      out_d.write_enable  = 1'b0;
      out_d.last          = 1'b1;
    end
  end

  always_comb begin
    start_column_d  = start_column_q;
    start_row_d     = start_row_q;
    span_columns_d  = span_columns_q;
    span_rows_d     = span_rows_q;
    row_count_d     = row_count_q;
    column_count_d  = column_count_q;
    row_shift_acc_d = row_shift_acc_q;
    vertical_acc_d  = vertical_acc_q;
    held_color_d    = held_color_q;
    held_shears_d   = held_shears_q;
    busy_d          = busy_q;

    if (cmd_i.ext_x) begin
      start_column_d = in_q.corner_x - ext_shift;
      span_columns_d = ext_span;
    end

    if (cmd_i.ext_y) begin
      start_row_d                          = in_q.corner_y - ext_shift;
      span_rows_d                          = ext_span;
      held_color_d                         = in_q.fill_color;
      held_shears_d[srf_pkg::SHEAR_ROW]    = in_q.row_shear;
      held_shears_d[srf_pkg::SHEAR_COLUMN] = in_q.column_shear;
      held_shears_d[srf_pkg::SHEAR_SECOND] = in_q.second_shear;
      row_count_d                          = '0;
      column_count_d                       = '0;
      row_shift_acc_d                      = '0;
      vertical_acc_d                       = '0;
      busy_d                               = (span_columns_q != '0) && (ext_span != '0);
    end

    if (cmd_i.vacc_load) begin
      vertical_acc_d = yp_q + held_shears_q[srf_pkg::SHEAR_COLUMN];
    end

    if (cmd_i.emit_load && busy_q) begin
      if (col_end) begin
        column_count_d = '0;
        if (row_end) begin
          busy_d = 1'b0;
        end else begin
          row_count_d     = row_next[15:0];
          row_shift_acc_d = row_shift_acc_q + held_shears_q[srf_pkg::SHEAR_ROW];
        end
      end else begin
        column_count_d = col_next[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_column_q  <= '0;
      start_row_q     <= '0;
      span_columns_q  <= '0;
      span_rows_q     <= '0;
      row_count_q     <= '0;
      column_count_q  <= '0;
      row_shift_acc_q <= '0;
      vertical_acc_q  <= '0;
      held_color_q    <= '0;
      for (int i = 0; i < srf_pkg::SHEAR_N; i++) begin
        held_shears_q[i] <= '0;
      end
      busy_q          <= 1'b0;
    end else begin
      start_column_q  <= start_column_d;
      start_row_q     <= start_row_d;
      span_columns_q  <= span_columns_d;
      span_rows_q     <= span_rows_d;
      row_count_q     <= row_count_d;
      column_count_q  <= column_count_d;
      row_shift_acc_q <= row_shift_acc_d;
      vertical_acc_q  <= vertical_acc_d;
      held_color_q    <= held_color_d;
      held_shears_q   <= held_shears_d;
      busy_q          <= busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q <= out_d;
    end
  end

  assign status_o.busy     = busy_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

FILE: hdl/sheared_scaled_rect_fill_core.sv
// ----------------------------------------------------------------------------
// Sheared scaled rectangle fill core
// Turns rectangle start and raster step transactions into pixel writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// A start transaction loads a rectangle (color, corner, size, signed 16.16
// scales and three 16.16 shear factors) and produces no output; each step
// transaction afterwards produces exactly one pixel write transaction with
// the frame-buffer address row * SCREEN_W + column, the color, a write flag
// that is low outside the viewport or screen, and a last flag. The input
// is stalled while a transaction is worked on: a start while its two
// extents are formed, a step while its shear products and column sum are
// formed and its result is loaded (only the load if no rectangle is
// pending), and a step also while the previous result is still held by a
// stalled output. These stalls come from the single shared 17 x 32 signed
// multiplier, which the two extents of a start and the two shear products
// of a step use in turn, and from the registered column sum ahead of the
// clipping compare. The output register lets the next transaction be taken
// while a result waits. The user must write the viewport registers through
// the plain write port only while the block is idle; the block does not enforce it.

module sheared_scaled_rect_fill_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  srf_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output srf_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [srf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Commands flow from the controller into the datapath; status flows back.
  srf_pkg::cmd_t    cmd;
  srf_pkg::status_t status;

  srf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  srf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // The input is stalled in the cycle after every accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken on two consecutive cycles");

  // A start transaction never leads to a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.opcode == srf_pkg::OP_START) &&
     !out_valid_o) |=> !out_valid_o)
    else $error("start transaction produced a result");

  // A new result is only loaded while a transaction is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in progress");

  // A clipped or idle pixel always carries a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.write_enable) |-> (out_data_o.pixel_address == '0))
    else $error("suppressed write carries a nonzero address");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Sheared scaled rectangle fill core: self-checking testbench
// Feeds rectangle start and raster step transactions with random idling on
// both handshakes, predicts every pixel write transaction in the testbench
// and compares the core's output against it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // Run control. The cycle limit is far above the slowest legal run: about
  // 1600 transactions, plus random gaps and stalls on both sides and one
  // long output hold-off.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_TICKS = 12;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 200;
  localparam int N_PHASES     = 8;

  // Handy 16.16 fixed-point values for the directed rows.
  localparam logic [31:0] FIX_ONE  = 32'h0001_0000;
  localparam logic [31:0] FIX_HALF = 32'h0000_8000;

  // Every input of the core holds a known value from time zero.
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  srf_pkg::in_item_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  srf_pkg::out_item_t             out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [srf_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [srf_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  sheared_scaled_rect_fill_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Raster state mirrored by the testbench. It follows the rectangle that the
  // last start transaction loaded and the viewport as last written.
  // --------------------------------------------------------------------------
  logic [15:0] org_col    = '0;
  logic [15:0] org_row    = '0;
  logic [15:0] cols_total = '0;
  logic [15:0] rows_total = '0;
  logic [15:0] row_idx    = '0;
  logic [15:0] col_idx    = '0;
  logic [15:0] held_rgb   = '0;
  logic [31:0] row_shift  = '0;
  logic [31:0] vert_acc   = '0;
  logic [31:0] shear_k [srf_pkg::SHEAR_N] = '{default: '0};
  bit          rect_live  = 1'b0;
  longint      vp_left    = 0;
  longint      vp_top     = 0;
  longint      vp_width   = 128;
  longint      vp_height  = 128;

  // Pixel writes that the core still owes us, oldest first.
  srf_pkg::out_item_t pending_pixels[$];

  int mismatches  = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit calm_phase  = 1'b0;
  bit hold_pending = 1'b0;

  // One row of the directed stimulus. Rows whose result is obvious carry it
  // typed in; the others are checked against the raster prediction.
  typedef struct {
    srf_pkg::in_item_t  item;
    bit                 typed;
    srf_pkg::out_item_t want;
  } plan_row_t;

  plan_row_t plan[$];

  // Scaled extent of one axis: floor(size * scale / 2^16). A negative extent
  // is mirrored, saturated to 16 bits, and reported as the corner shift.
  function automatic longint scaled_span(input logic [15:0] size, input logic [31:0] scale,
                                         output longint back);
    longint e;
    e = (longint'(size) * longint'($signed(scale))) >>> 16;
    back = 0;
    if (e < 0) begin
      e = -e;
      if (e > 65535) e = 65535;
      back = e;
    end
    if (e > 65535) e = 65535;
    return e;
  endfunction

  // Advances the mirrored raster by one accepted transaction. A start loads
  // a rectangle and yields nothing; a step yields exactly one pixel write.
  task automatic raster_step(input srf_pkg::in_item_t it, output bit emits,
                             output srf_pkg::out_item_t px);
    longint ex, ey, mx, my, y0, r, c, xs, row, x2, col;
    logic [31:0] yp;
    bit on;
    px = '0;
    emits = 1'b0;
    if (it.opcode == srf_pkg::OP_START) begin
      ex = scaled_span(it.rect_width, it.scale_x, mx);
      ey = scaled_span(it.rect_height, it.scale_y, my);
      held_rgb   = it.fill_color;
      // The mirrored corner simply wraps to 16 bits.
      org_col    = 16'(longint'($signed(it.corner_x)) - mx);
      org_row    = 16'(longint'($signed(it.corner_y)) - my);
      cols_total = 16'(ex);
      rows_total = 16'(ey);
      shear_k[srf_pkg::SHEAR_ROW]    = it.row_shear;
      shear_k[srf_pkg::SHEAR_COLUMN] = it.column_shear;
      shear_k[srf_pkg::SHEAR_SECOND] = it.second_shear;
      row_idx   = '0;
      col_idx   = '0;
      row_shift = '0;
      vert_acc  = '0;
      // An empty extent on either axis leaves nothing to draw.
      rect_live = (ex != 0) && (ey != 0);
    end else begin
      emits = 1'b1;
      px.pixel_color = held_rgb;
      if (!rect_live) begin
        // Nothing left to draw: a dummy write flagged as last.
        px.last = 1'b1;
      end else begin
        r  = longint'(row_idx);
        c  = longint'(col_idx);
        y0 = longint'($signed(org_row));
        xs = longint'($signed(row_shift)) >>> 16;
        // The vertical accumulator restarts at the head of each row and
        // then grows by the column shear, wrapping at 32 bits.
        if (c == 0) begin
          yp = 32'((y0 + r) * 65536 +
                   xs * longint'($signed(shear_k[srf_pkg::SHEAR_COLUMN])));
        end else begin
          yp = vert_acc;
        end
        row = longint'($signed(yp[31:16]));
        x2  = ((row - y0) * longint'($signed(shear_k[srf_pkg::SHEAR_SECOND]))) >>> 16;
        col = longint'($signed(org_col)) + c + xs + x2;
        vert_acc = yp + shear_k[srf_pkg::SHEAR_COLUMN];
        on = col >= vp_left && row >= vp_top &&
             col < vp_left + vp_width && row < vp_top + vp_height &&
             col >= 0 && row >= 0 &&
             col < longint'(srf_pkg::SCREEN_W) && row < longint'(srf_pkg::SCREEN_H);
        if (on) begin
          px.pixel_address = srf_pkg::ADDR_W'(row * longint'(srf_pkg::SCREEN_W) + col);
          px.write_enable  = 1'b1;
        end
        if (c + 1 >= longint'(cols_total)) begin
          col_idx = '0;
          if (r + 1 >= longint'(rows_total)) begin
            rect_live = 1'b0;
            px.last   = 1'b1;
          end else begin
            row_idx   = 16'(r + 1);
            row_shift = row_shift + shear_k[srf_pkg::SHEAR_ROW];
          end
        end else begin
          col_idx = 16'(c + 1);
        end
      end
    end
  endtask

  // Length of one idle stretch: mostly short, now and then long.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 45);
  endfunction

  // A transaction with every field random.
  function automatic srf_pkg::in_item_t junk_item();
    srf_pkg::in_item_t it;
    it.opcode       = 1'($urandom);
    it.fill_color   = 16'($urandom);
    it.corner_x     = 16'($urandom);
    it.corner_y     = 16'($urandom);
    it.rect_width   = 16'($urandom);
    it.rect_height  = 16'($urandom);
    it.scale_x      = $urandom;
    it.scale_y      = $urandom;
    it.row_shear    = $urandom;
    it.column_shear = $urandom;
    it.second_shear = $urandom;
    return it;
  endfunction

  // Steps carry random junk in the unused fields; the core must ignore it.
  function automatic srf_pkg::in_item_t step_item();
    srf_pkg::in_item_t it;
    it = junk_item();
    it.opcode = srf_pkg::OP_STEP;
    return it;
  endfunction

  function automatic srf_pkg::in_item_t rect_item(input logic [15:0] rgb, cx, cy, w, h,
                                                  input logic [31:0] sx, sy, rs, cs, ss);
    srf_pkg::in_item_t it;
    it.opcode       = srf_pkg::OP_START;
    it.fill_color   = rgb;
    it.corner_x     = cx;
    it.corner_y     = cy;
    it.rect_width   = w;
    it.rect_height  = h;
    it.scale_x      = sx;
    it.scale_y      = sy;
    it.row_shear    = rs;
    it.column_shear = cs;
    it.second_shear = ss;
    return it;
  endfunction

  // Random start. A tame one stays near the screen with a small extent and
  // modest shears so that the raster finishes; a wild one is all noise.
  function automatic srf_pkg::in_item_t random_rect(input bit wild);
    srf_pkg::in_item_t it;
    it = junk_item();
    it.opcode = srf_pkg::OP_START;
    if (!wild) begin
      if ($urandom_range(0, 9) != 0) begin
        it.corner_x = 16'($urandom_range(0, 150) - 20);
        it.corner_y = 16'($urandom_range(0, 150) - 20);
      end
      it.rect_width  = 16'($urandom_range(0, 6));
      it.rect_height = 16'($urandom_range(0, 6));
      it.scale_x = 32'($urandom_range(0, 32'h4_0000) - 32'h2_0000);
      it.scale_y = 32'($urandom_range(0, 32'h4_0000) - 32'h2_0000);
      if ($urandom_range(0, 3) != 0)
        it.row_shear = 32'($urandom_range(0, 32'h2_0000) - 32'h1_0000);
      if ($urandom_range(0, 3) != 0)
        it.column_shear = 32'($urandom_range(0, 32'h2_0000) - 32'h1_0000);
      if ($urandom_range(0, 3) != 0)
        it.second_shear = 32'($urandom_range(0, 32'h2_0000) - 32'h1_0000);
    end
    return it;
  endfunction

  function automatic srf_pkg::out_item_t pix(input int addr, input logic [15:0] rgb,
                                             input logic we, input logic fin);
    srf_pkg::out_item_t px;
    px.pixel_address = srf_pkg::ADDR_W'(addr);
    px.pixel_color   = rgb;
    px.write_enable  = we;
    px.last          = fin;
    return px;
  endfunction

  // Presents one transaction and returns at the edge where it is taken. The
  // caller must then either offer the next one or drop valid in this step.
  task automatic offer(input srf_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Random gap on the input side; valid only drops when a gap is taken.
  task automatic sender_gap();
    int n;
    n = 0;
    if (!calm_phase && $urandom_range(0, 99) >= 55) n = idle_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_and_track(input srf_pkg::in_item_t it, input bit typed,
                                input srf_pkg::out_item_t want);
    bit                 emits;
    srf_pkg::out_item_t px;
    offer(it);
    raster_step(it, emits, px);
    if (emits) pending_pixels.push_back(typed ? want : px);
    items_sent++;
    sender_gap();
  endtask

  // Stops offering and waits until every owed pixel has arrived, then lets
  // a start that is still being worked on finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic poke(input srf_pkg::cfg_idx_e idx, input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    case (idx)
      srf_pkg::CFG_VIEW_LEFT:   vp_left   = longint'($signed(v));
      srf_pkg::CFG_VIEW_TOP:    vp_top    = longint'($signed(v));
      srf_pkg::CFG_VIEW_WIDTH:  vp_width  = longint'(v);
      srf_pkg::CFG_VIEW_HEIGHT: vp_height = longint'(v);
      default: ;
    endcase
  endtask

  // Only called with the core idle.
  task automatic load_viewport(input logic [15:0] left, top, width, height);
    poke(srf_pkg::CFG_VIEW_LEFT, left);
    poke(srf_pkg::CFG_VIEW_TOP, top);
    poke(srf_pkg::CFG_VIEW_WIDTH, width);
    poke(srf_pkg::CFG_VIEW_HEIGHT, height);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_pixel(input srf_pkg::out_item_t got);
    srf_pkg::out_item_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected pixel write transaction: address %0d", got.pixel_address);
      mismatches++;
    end else begin
      want = pending_pixels.pop_front();
      if (got.pixel_address !== want.pixel_address) begin
        $error("pixel_address: expected %0d, got %0d", want.pixel_address, got.pixel_address);
        mismatches++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
        mismatches++;
      end
      if (got.write_enable !== want.write_enable) begin
        $error("write_enable: expected %b, got %b", want.write_enable, got.write_enable);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        mismatches++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and the run limit.
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: checks each pixel write transaction as it is taken and
  // stalls at random. A request from the stimulus turns into one long
  // hold-off so the core backs up and stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) check_pixel(out_data_o);
    if (hold_pending) begin
      hold_pending = 1'b0;
      stall_left   = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm_phase && $urandom_range(0, 99) >= 70) begin
      stall_left = idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: a directed table first, then random phases, each under its own
  // viewport setting.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    int steps;
    int roll;

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    // Step before any rectangle: the reset color and a dummy last write.
    plan.push_back('{step_item(), 1'b1, pix(0, 16'h0000, 1'b0, 1'b1)});
    // A plain 2 x 2 square at the origin, all inside the reset viewport.
    plan.push_back('{rect_item(16'hFFFF, 0, 0, 2, 2, FIX_ONE, FIX_ONE, 0, 0, 0),
                     1'b0, '0});
    plan.push_back('{step_item(), 1'b1, pix(0, 16'hFFFF, 1'b1, 1'b0)});
    plan.push_back('{step_item(), 1'b1, pix(1, 16'hFFFF, 1'b1, 1'b0)});
    plan.push_back('{step_item(), 1'b1, pix(128, 16'hFFFF, 1'b1, 1'b0)});
    plan.push_back('{step_item(), 1'b1, pix(129, 16'hFFFF, 1'b1, 1'b1)});
    // Once the raster is done, further steps are dummy writes.
    plan.push_back('{step_item(), 1'b1, pix(0, 16'hFFFF, 1'b0, 1'b1)});
    // Zero width, then zero vertical scale: both leave the core idle.
    plan.push_back('{rect_item(16'h1234, 3, 3, 0, 4, FIX_ONE, FIX_ONE, 0, 0, 0),
                     1'b0, '0});
    plan.push_back('{step_item(), 1'b1, pix(0, 16'h1234, 1'b0, 1'b1)});
    plan.push_back('{rect_item(16'h0001, 3, 3, 5, 5, FIX_ONE, 0, 0, 0, 0),
                     1'b0, '0});
    plan.push_back('{step_item(), 1'b1, pix(0, 16'h0001, 1'b0, 1'b1)});
    // Negative horizontal scale mirrors a 3-wide row back from column 5.
    plan.push_back('{rect_item(16'hA5A5, 5, 7, 3, 1, -FIX_ONE, FIX_ONE, 0, 0, 0),
                     1'b0, '0});
    plan.push_back('{step_item(), 1'b1, pix(898, 16'hA5A5, 1'b1, 1'b0)});
    plan.push_back('{step_item(), 1'b1, pix(899, 16'hA5A5, 1'b1, 1'b0)});
    plan.push_back('{step_item(), 1'b1, pix(900, 16'hA5A5, 1'b1, 1'b1)});
    // Extreme corner, size, scales and shears: saturated extents and a
    // wrapped corner, far off screen.
    plan.push_back('{rect_item(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF), 1'b0, '0});
    plan.push_back('{step_item(), 1'b0, '0});
    plan.push_back('{step_item(), 1'b0, '0});
    // A sheared 3 x 2 rectangle that replaces the one still in progress.
    plan.push_back('{rect_item(16'h5A5A, 10, 10, 3, 2, FIX_ONE, FIX_ONE,
                               FIX_HALF, FIX_HALF, -FIX_HALF), 1'b0, '0});
    repeat (6) plan.push_back('{step_item(), 1'b0, '0});

    foreach (plan[i]) send_and_track(plan[i].item, plan[i].typed, plan[i].want);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // The core is idle here, so the viewport may change.
      case (ph)
        1: load_viewport(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        3: load_viewport(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        4: load_viewport(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        5: load_viewport(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        7: load_viewport(16'd16, 16'd8, 16'd64, 16'd100);
        default: load_viewport(16'($urandom_range(0, 60) - 20),
                               16'($urandom_range(0, 60) - 20),
                               16'($urandom_range(0, 140)),
                               16'($urandom_range(0, 140)));
      endcase
      // One phase runs without any idling at all; another opens with the
      // long output hold-off while steps keep coming.
      calm_phase = (ph == 5);
      if (ph == 2) hold_pending = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          // Well-formed rectangle walked to its end, sometimes past it with
          // a few dummy steps, sometimes cut short by the next start.
          send_and_track(random_rect(1'b0), 1'b0, '0);
          steps = rect_live ? int'(cols_total) * int'(rows_total) : 0;
          steps += $urandom_range(0, 2);
          if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
        end else if (roll < 92) begin
          send_and_track(random_rect(1'b1), 1'b0, '0);
          steps = $urandom_range(0, 6);
        end else begin
          send_and_track(junk_item(), 1'b0, '0);
          steps = 0;
        end
        repeat (steps) send_and_track(step_item(), 1'b0, '0);
        if ($urandom_range(0, 49) == 0) drain();
      end
      drain();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
